### src/kmp_pkg.sv
// Shared types and constants for the k-step Fibonacci matrix power block.
package kmp_pkg;
	localparam int MaxOrder = 8;
	localparam int IdxW = $clog2(MaxOrder);
	localparam int CellW = 2 * IdxW;
	localparam int Cells = MaxOrder * MaxOrder;
	localparam int ValW = 32;
	localparam logic [3:0] OrderReset = 4'd2;
	localparam logic [31:0] ModReset = 32'd1000000009;
	localparam logic CfgOrder = 1'b0;
	localparam logic CfgModulus = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_CHECK, ST_MUL_RD, ST_MUL_WAIT, ST_MAC_MUL, ST_MAC_RED,
		ST_MAC_ADD, ST_STORE, ST_COPY_RD, ST_COPY_WR, ST_NEXT, ST_DONE
	} state_t;
endpackage

### src/kbonacci_matrix_power_mod.sv
// k-step Fibonacci matrix power modulo a configured modulus: top level and sequencer.
// Each exponent beat runs square-and-multiply: one matrix product per exponent bit for
// the squaring and one more for each set bit, up to 62 products. A product takes
// order^3 multiply-adds (each two RAM reads, the multiplier launch, the bit-serial
// modular multiplier and one add), a store per entry, a copy back of all 64 cells and
// the ST_NEXT and ST_CHECK bookkeeping states. Exponent zero goes from the table init
// straight to the result. busy is high from start until the element strobe; the strobe
// lasts one cycle and cannot be stalled. Configure only while busy is low.
module kbonacci_matrix_power_mod import kmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] exponent,
	output logic        element_valid,
	output logic [31:0] element,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	state_t state_q, state_d;
	logic [3:0]       order_q;
	logic [ValW-1:0]  mod_q;
	logic [IdxW:0]    k_q;
	logic [30:0]      exp_q;
	logic             sq_q;   // 0: accum*base, 1: base*base
	logic [IdxW:0]    i_q, j_q, z_q;
	logic [ValW-1:0]  sum_q, opa_q;
	logic [CellW:0]   c_q;
	logic             mm_go, mm_done;
	logic [ValW-1:0]  mm_p;
	logic [ValW:0]    add;

	// RAM ports
	logic             acc_we, base_we, scr_we;
	logic [CellW-1:0] acc_wa, base_wa, scr_wa, acc_ra, base_ra, scr_ra;
	logic [ValW-1:0]  acc_wd, base_wd, scr_wd, acc_rd, base_rd, scr_rd;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= OrderReset;
			mod_q   <= ModReset;
		end else if (cfg_valid) begin
			if (cfg_index == CfgOrder) order_q <= cfg_data[3:0];
			else mod_q <= cfg_data;
		end
	end

	kmp_ram #(.Width(ValW), .Depth(Cells)) u_acc (.clk, .we(acc_we), .waddr(acc_wa),
		.wdata(acc_wd), .raddr(acc_ra), .rdata(acc_rd));
	kmp_ram #(.Width(ValW), .Depth(Cells)) u_base (.clk, .we(base_we), .waddr(base_wa),
		.wdata(base_wd), .raddr(base_ra), .rdata(base_rd));
	kmp_ram #(.Width(ValW), .Depth(Cells)) u_scr (.clk, .we(scr_we), .waddr(scr_wa),
		.wdata(scr_wd), .raddr(scr_ra), .rdata(scr_rd));

	kmp_modmul u_mul (.clk, .arst_n, .go(mm_go), .a(opa_q), .b(base_rd), .m(mod_q),
		.done(mm_done), .p(mm_p));

	logic [CellW-1:0] cell_iz, cell_zj, cell_ij, cell_c;
	assign cell_iz = {i_q[IdxW-1:0], z_q[IdxW-1:0]};
	assign cell_zj = {z_q[IdxW-1:0], j_q[IdxW-1:0]};
	assign cell_ij = {i_q[IdxW-1:0], j_q[IdxW-1:0]};
	assign cell_c  = c_q[CellW-1:0];
	assign add = {1'b0, sum_q} + {1'b0, mm_p};

	always_comb begin
		state_d = state_q;
		mm_go = 1'b0;
		acc_we = 1'b0; base_we = 1'b0; scr_we = 1'b0;
		acc_wa = cell_c; base_wa = cell_c; scr_wa = cell_ij;
		acc_wd = '0; base_wd = '0;
		scr_wd = sum_q;
		acc_ra = cell_iz; base_ra = cell_zj; scr_ra = cell_c;
		if (sq_q) base_ra = (state_q == ST_MUL_RD) ? cell_iz : cell_zj;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_INIT;
			ST_INIT: begin
				acc_we = 1'b1; base_we = 1'b1;
				acc_wd = (c_q[CellW-1:IdxW] == c_q[IdxW-1:0]) ? ValW'(1) : '0;
				base_wd = (c_q[IdxW-1:0] == '0 ||
					{1'b0, c_q[IdxW-1:0]} == {1'b0, c_q[CellW-1:IdxW]} + 1'b1)
					? ValW'(1) : '0;
				if (c_q == (CellW+1)'(Cells - 1)) state_d = ST_CHECK;
			end
			ST_CHECK: if (exp_q == '0) state_d = ST_DONE; else state_d = ST_MUL_RD;
			ST_MUL_RD: state_d = ST_MUL_WAIT;   // read a[i][z] (into opa next)
			ST_MUL_WAIT: state_d = ST_MAC_MUL;  // read b[z][j]
			ST_MAC_MUL: begin
				mm_go = 1'b1;
				state_d = ST_MAC_RED;
			end
			ST_MAC_RED: if (mm_done) state_d = ST_MAC_ADD;
			ST_MAC_ADD: begin
				if (z_q == k_q - 1'b1) state_d = ST_STORE;
				else state_d = ST_MUL_RD;
			end
			ST_STORE: begin
				scr_we = 1'b1;
				if (i_q == k_q - 1'b1 && j_q == k_q - 1'b1) state_d = ST_COPY_RD;
				else state_d = ST_MUL_RD;
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: begin
				acc_we = !sq_q; base_we = sq_q;
				acc_wd = scr_rd; base_wd = scr_rd;
				if (c_q == (CellW+1)'(Cells - 1)) state_d = ST_NEXT;
				else state_d = ST_COPY_RD;
			end
			ST_NEXT: state_d = ST_CHECK;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_COPY_WR) begin
			acc_wa = cell_c; base_wa = cell_c;
		end
		if (state_q == ST_DONE) acc_ra = '0;
		if (state_q == ST_CHECK && exp_q == '0) acc_ra = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			element_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			element_valid <= (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				exp_q <= exponent;
				sq_q <= !exponent[0];
				c_q <= '0;
				k_q <= (order_q == 4'd0) ? (IdxW+1)'(1) :
					(order_q > 4'(MaxOrder)) ? (IdxW+1)'(MaxOrder) : order_q[IdxW:0];
			end
			ST_INIT: c_q <= c_q + 1'b1;
			ST_CHECK: begin
				i_q <= '0; j_q <= '0; z_q <= '0; sum_q <= '0;
			end
			ST_MUL_WAIT: opa_q <= sq_q ? base_rd : acc_rd;
			ST_MAC_ADD: begin
				sum_q <= (add >= {1'b0, mod_q}) ? ValW'(add - {1'b0, mod_q}) : add[ValW-1:0];
				z_q <= z_q + 1'b1;
			end
			ST_STORE: begin
				sum_q <= '0; z_q <= '0;
				if (j_q == k_q - 1'b1) begin
					j_q <= '0; i_q <= i_q + 1'b1;
				end else j_q <= j_q + 1'b1;
				c_q <= '0;
			end
			ST_COPY_WR: c_q <= c_q + 1'b1;
			ST_NEXT: begin
				if (sq_q) begin
					exp_q <= exp_q >> 1;
					sq_q <= !exp_q[1];
				end else sq_q <= 1'b1;
				i_q <= '0; j_q <= '0; z_q <= '0; sum_q <= '0;
			end
			ST_DONE: element <= (mod_q < ValW'(2)) ? '0 : acc_rd;
			default: ;
		endcase
	end
endmodule

### src/kmp_ram.sv
// Generic single write port RAM with registered read.
module kmp_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/kmp_modmul.sv
// Sequential shift-add modular multiplier: one bit of b per cycle.
module kmp_modmul import kmp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [ValW-1:0] a,
	input  logic [ValW-1:0] b,
	input  logic [ValW-1:0] m,
	output logic            done,
	output logic [ValW-1:0] p
);
	logic [ValW:0]          acc_q, a_q;
	logic [ValW-1:0]        b_q;
	logic [$clog2(ValW):0]  cnt_q;
	logic                   run_q;
	logic [ValW+1:0]        dbl, sum;
	logic [ValW:0]          dbl_r, acc_n, a_n;

	// operands stay below m, so one subtract reduces each step
	always_comb begin
		dbl   = {1'b0, acc_q} << 1;
		dbl_r = (dbl >= {2'b0, m}) ? (ValW+1)'(dbl - {2'b0, m}) : dbl[ValW:0];
		sum   = {1'b0, dbl_r} + {1'b0, a_q};
		acc_n = b_q[ValW-1] ? ((sum >= {2'b0, m}) ? (ValW+1)'(sum - {2'b0, m})
			: sum[ValW:0]) : dbl_r;
		a_n   = a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(ValW)+1)'(ValW - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			a_q   <= {1'b0, a};
			b_q   <= b;
		end else if (run_q) begin
			acc_q <= acc_n;
			a_q   <= a_n;
			b_q   <= b_q << 1;
		end
	end

	assign p = acc_q[ValW-1:0];
endmodule
